@@ rtl/fwr2d_pkg.sv @@
// Shared types and constants for the 2D full-weighting restriction unit.
`default_nettype none

package fwr2d_pkg;

  localparam int unsigned DATA_W    = 32;  // Q15.16 sample and result width
  localparam int unsigned CFG_W     = 11;  // fine_size register width
  localparam int unsigned CSUM_W    = DATA_W + 2;  // top + 2*mid + bottom
  localparam int unsigned TSUM_W    = DATA_W + 4;  // full 3x3 weighted sum
  localparam int unsigned FRAC_SHIFT = 4;          // divide by 16
  localparam logic [CFG_W-1:0] FINE_SIZE_RESET = CFG_W'(1023);

  // Per-sample tag computed from the raster position.
  typedef struct packed {
    logic emit;  // this sample completes a coarse point
    logic last;  // the coarse point is the final one of the grid
  } tag_t;

endpackage

`default_nettype wire

@@ rtl/full_weighting_restriction_2d_unit.sv @@
// Top level of the streaming 2D full-weighting restriction unit.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------------
//   in_      | in  | in_tvalid / in_tready  | in_tdata[31:0] = fine_sample
//   out_     | out | out_tvalid / out_tready| out_tdata[31:0] = coarse_value,
//            |     |                        | out_tlast = coarse_last
//   cfg_     | in  | cfg_wr_en              | cfg_wr_data[10:0] = fine_size
//
// One fine sample is taken each cycle unless the output stalls; a coarse value
// follows its completing sample via line-buffer read, column sum, window sum.
// The whole pipeline stalls together only while the output register holds an
// untaken beat. Reset clears counters and valid flags, sets fine_size to 1023,
// and needs no clearing pass; line-buffer entries are always written before use.
`default_nettype none

module full_weighting_restriction_2d_unit #(
  parameter int unsigned MAX_FINE = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic [fwr2d_pkg::DATA_W-1:0] in_tdata,    // [31:0] fine_sample
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  output      logic [fwr2d_pkg::DATA_W-1:0] out_tdata,   // [31:0] coarse_value
  output      logic                         out_tlast,   // coarse_last
  input  wire logic                         cfg_wr_en,
  input  wire logic [fwr2d_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int unsigned CW = $clog2(MAX_FINE);
  localparam int unsigned DW = fwr2d_pkg::DATA_W;
  localparam int unsigned CSW = fwr2d_pkg::CSUM_W;
  localparam int unsigned TSW = fwr2d_pkg::TSUM_W;

  logic            adv;
  logic            in_beat;
  logic [CW-1:0]   col;
  fwr2d_pkg::tag_t tag;

  // Stage 1: sample with its line-buffer word on the way.
  logic                 s1_valid_r;
  logic [DW-1:0]        s1_sample_r;
  logic [CW-1:0]        s1_col_r;
  fwr2d_pkg::tag_t      s1_tag_r;
  logic                 fwd_r;
  logic [2*DW-1:0]      fwd_data_r;
  logic [2*DW-1:0]      rd_word;
  logic [2*DW-1:0]      s1_word;
  logic [DW-1:0]        s1_top;
  logic [DW-1:0]        s1_mid;
  logic signed [CSW-1:0] s1_csum;

  // Stage 2: column sum of the newest column.
  logic                  s2_valid_r;
  fwr2d_pkg::tag_t       s2_tag_r;
  logic signed [CSW-1:0] s2_csum_r;
  logic signed [CSW-1:0] cs1_r;   // column c-1
  logic signed [CSW-1:0] cs2_r;   // column c-2
  logic signed [TSW-1:0] tsum;

  logic          out_valid_r;
  logic [DW-1:0] out_data_r;
  logic          out_last_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_beat   = in_tvalid && adv;

  fwr2d_ctrl #(.MAX_FINE(MAX_FINE)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (in_beat),
    .col         (col),
    .tag         (tag)
  );

  fwr2d_line_buf #(.DEPTH(MAX_FINE), .WIDTH(2 * DW)) u_line_buf (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (col),
    .rd_data (rd_word),
    .wr_en   (adv && s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data ({s1_mid, s1_sample_r})
  );

  // A read that collides with the write of the sample ahead of it takes the new word.
  assign s1_word = fwd_r ? fwd_data_r : rd_word;
  assign s1_top  = s1_word[2*DW-1:DW];
  assign s1_mid  = s1_word[DW-1:0];
  assign s1_csum = CSW'($signed(s1_top)) + (CSW'($signed(s1_mid)) <<< 1)
                   + CSW'($signed(s1_sample_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
      fwd_r      <= s1_valid_r && (s1_col_r == col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample_r <= in_tdata;
      s1_col_r    <= col;
      s1_tag_r    <= tag;
      fwd_data_r  <= {s1_mid, s1_sample_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r  <= s1_tag_r;
      s2_csum_r <= s1_csum;
    end
  end

  // The window keeps column sums; zero columns sum to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs1_r <= '0;
      cs2_r <= '0;
    end else if (adv && s2_valid_r) begin
      cs1_r <= s2_csum_r;
      cs2_r <= cs1_r;
    end
  end

  assign tsum = TSW'(cs2_r) + (TSW'(cs1_r) <<< 1) + TSW'(s2_csum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= tsum[TSW-1:fwr2d_pkg::FRAC_SHIFT];
      out_last_r <= s2_tag_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/fwr2d_ctrl.sv @@
// Raster position counters, size register and coarse-point decode.
`default_nettype none

module fwr2d_ctrl #(
  parameter int unsigned MAX_FINE = 1024,
  localparam int unsigned CW = $clog2(MAX_FINE)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [fwr2d_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                        step,
  output      logic [CW-1:0]               col,
  output      fwr2d_pkg::tag_t             tag
);

  localparam int unsigned SW = CW + 1;
  localparam int unsigned XW = (SW > fwr2d_pkg::CFG_W) ? SW : fwr2d_pkg::CFG_W;

  logic [fwr2d_pkg::CFG_W-1:0] fine_size_r;
  logic [CW-1:0]               row_r, row_nxt;
  logic [CW-1:0]               col_r, col_nxt;
  logic [XW-1:0]               size_x;
  logic [CW-1:0]               last_idx;   // n - 1
  logic [CW-1:0]               lim;        // 2 * coarse size

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_size_r <= fwr2d_pkg::FINE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      fine_size_r <= cfg_wr_data;
    end
  end

  // The effective side saturates to 1..MAX_FINE.
  always_comb begin
    size_x = XW'(fine_size_r);
    if (size_x == '0) begin
      last_idx = '0;
    end else if (size_x > XW'(MAX_FINE)) begin
      last_idx = CW'(MAX_FINE - 1);
    end else begin
      last_idx = CW'(size_x - XW'(1));
    end
    lim = {last_idx[CW-1:1], 1'b0};
  end

  always_comb begin
    tag.emit = !row_r[0] && !col_r[0] && (row_r[CW-1:1] != '0) && (col_r[CW-1:1] != '0)
               && (row_r <= lim) && (col_r <= lim);
    tag.last = (row_r == lim) && (col_r == lim);
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r + CW'(1);
    if (col_r >= last_idx) begin
      col_nxt = '0;
      row_nxt = (row_r >= last_idx) ? '0 : row_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (step) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign col = col_r;

endmodule

`default_nettype wire

@@ rtl/fwr2d_line_buf.sv @@
// Two fine-row line buffers held side by side in one memory word.
`default_nettype none

module fwr2d_line_buf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/fwr2d_checker.sv @@
// Port-level checks for the 2D full-weighting restriction unit, bound to the top.
`default_nettype none

module fwr2d_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [fwr2d_pkg::DATA_W-1:0] out_tdata,
  input wire logic                         out_tlast
);

  // The input side is held back only while an output beat waits.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not track output backpressure");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // While stalled no new sample may enter.
  a_no_entry_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(in_tvalid && in_tready))
    else $error("input beat taken during output stall");

endmodule

bind full_weighting_restriction_2d_unit fwr2d_checker u_fwr2d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
